// ===== hw/rtl/mve_pkg.sv =====
`default_nettype none
package mve_pkg;

  typedef enum logic [2:0] {
    CMD_INT32   = 3'd0,
    CMD_INT64   = 3'd1,
    CMD_ARRAY   = 3'd2,
    CMD_STRING  = 3'd3,
    CMD_PAYLOAD = 3'd4,
    CMD_FLOAT32 = 3'd5,
    CMD_BOOL    = 3'd6
  } cmd_t;

  localparam logic [7:0] MK_UINT8   = 8'hcc;
  localparam logic [7:0] MK_UINT16  = 8'hcd;
  localparam logic [7:0] MK_UINT32  = 8'hce;
  localparam logic [7:0] MK_INT8    = 8'hd0;
  localparam logic [7:0] MK_INT16   = 8'hd1;
  localparam logic [7:0] MK_INT32   = 8'hd2;
  localparam logic [7:0] MK_INT64   = 8'hd3;
  localparam logic [7:0] MK_FLOAT32 = 8'hca;
  localparam logic [7:0] MK_FIXSTR  = 8'ha0;
  localparam logic [7:0] MK_STR8    = 8'hd9;
  localparam logic [7:0] MK_STR16   = 8'hda;
  localparam logic [7:0] MK_STR32   = 8'hdb;
  localparam logic [7:0] MK_FIXARR  = 8'h90;
  localparam logic [7:0] MK_ARR16   = 8'hdc;
  localparam logic [7:0] MK_ARR32   = 8'hdd;
  localparam logic [7:0] MK_FALSE   = 8'hc2;
  localparam logic [7:0] MK_TRUE    = 8'hc3;

  localparam int QUEUE_DEPTH_DEF = 2;

  // One classified element: marker byte, trailing bytes left-aligned, and
  // the number of trailing bytes (0, 1, 2, 4 or 8).
  typedef struct packed {
    logic [7:0]  marker;
    logic [63:0] data;
    logic [3:0]  nbytes;
  } elem_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/msgpack_value_encoder_unit.sv =====
`default_nettype none
// Channel   Signals                          Handshake
// -------   ------------------------------   ------------------------------
// request   cmd, operand, count              taken when start & !busy
// result    out_byte, last                   one cycle each, marked by strobe
//
// An element of N trailing bytes is sent as its marker byte and then those N
// bytes through the single byte-wide output register of the emitter; queued
// elements follow one another on the result side without a gap.
// An accepted item passes through a queue slot and the emitter's element
// registers. Reset (rst, synchronous) empties the queue and idles the emitter.
// busy is high only while the element queue is full; the receiver never stalls.
module msgpack_value_encoder_unit #(
  parameter int QUEUE_DEPTH = mve_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  cmd,
  input  wire logic [63:0] operand,
  input  wire logic [31:0] count,
  output logic [7:0]       out_byte,
  output logic             last,
  output logic             strobe
);
  import mve_pkg::*;

  elem_t     front_elem;
  logic      front_valid;
  elem_t     head;
  q_status_t q_status;
  logic      pop;
  logic      push;

  // The front end classifies the request into a marker byte and a
  // left-aligned run of trailing bytes in the accepting cycle.
  mve_front u_front (
    .cmd        (cmd),
    .operand    (operand),
    .count      (count),
    .elem       (front_elem),
    .elem_valid (front_valid)
  );

  // An unknown command is accepted but never reaches the queue.
  assign busy = q_status.full;
  assign push = start && !busy && front_valid;

  // A short queue lets new items be taken while earlier ones are still
  // being streamed out.
  mve_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_elem (front_elem),
    .pop     (pop),
    .rd_elem (head),
    .status  (q_status)
  );

  // The back end streams each element one byte per cycle, marker first.
  mve_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_byte (out_byte),
    .last     (last),
    .strobe   (strobe)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/mve_front.sv =====
`default_nettype none
module mve_front (
  input  wire logic [2:0]  cmd,
  input  wire logic [63:0] operand,
  input  wire logic [31:0] count,
  output mve_pkg::elem_t   elem,
  output logic             elem_valid
);
  import mve_pkg::*;

  logic signed [63:0] v;
  logic               wide;
  logic        [63:0] u;

  always_comb begin
    wide = (cmd == CMD_INT64);
    v = wide ? $signed(operand) : $signed({{32{operand[31]}}, operand[31:0]});
    u = v;
    elem_valid = 1'b1;
    elem.marker = 8'h00;
    elem.data = 64'd0;
    elem.nbytes = 4'd0;
    case (cmd)
      CMD_INT32, CMD_INT64: begin
        if (v >= -64'sd32 && v <= 64'sd127) begin
          elem.marker = u[7:0];
        end else if (v >= -64'sd128 && v < -64'sd32) begin
          elem.marker = MK_INT8;
          elem.data = {u[7:0], 56'd0};
          elem.nbytes = 4'd1;
        end else if (v >= 64'sd128 && v <= 64'sd255) begin
          elem.marker = MK_UINT8;
          elem.data = {u[7:0], 56'd0};
          elem.nbytes = 4'd1;
        end else if (v >= -64'sd32768 && v < -64'sd128) begin
          elem.marker = MK_INT16;
          elem.data = {u[15:0], 48'd0};
          elem.nbytes = 4'd2;
        end else if (v > 64'sd255 && v <= 64'sd65535) begin
          elem.marker = MK_UINT16;
          elem.data = {u[15:0], 48'd0};
          elem.nbytes = 4'd2;
        end else if (!wide || (v >= -64'sd2147483648 && v <= -64'sd32769)) begin
          elem.marker = MK_INT32;
          elem.data = {u[31:0], 32'd0};
          elem.nbytes = 4'd4;
        end else if (v > 64'sd65535 && v <= 64'sd4294967295) begin
          elem.marker = MK_UINT32;
          elem.data = {u[31:0], 32'd0};
          elem.nbytes = 4'd4;
        end else begin
          elem.marker = MK_INT64;
          elem.data = u;
          elem.nbytes = 4'd8;
        end
      end
      CMD_ARRAY: begin
        if (count <= 32'd15) begin
          elem.marker = MK_FIXARR | {4'd0, count[3:0]};
        end else if (count <= 32'd65535) begin
          elem.marker = MK_ARR16;
          elem.data = {count[15:0], 48'd0};
          elem.nbytes = 4'd2;
        end else begin
          elem.marker = MK_ARR32;
          elem.data = {count, 32'd0};
          elem.nbytes = 4'd4;
        end
      end
      CMD_STRING: begin
        if (count <= 32'd31) begin
          elem.marker = MK_FIXSTR | {3'd0, count[4:0]};
        end else if (count <= 32'd255) begin
          elem.marker = MK_STR8;
          elem.data = {count[7:0], 56'd0};
          elem.nbytes = 4'd1;
        end else if (count <= 32'd65535) begin
          elem.marker = MK_STR16;
          elem.data = {count[15:0], 48'd0};
          elem.nbytes = 4'd2;
        end else begin
          elem.marker = MK_STR32;
          elem.data = {count, 32'd0};
          elem.nbytes = 4'd4;
        end
      end
      CMD_PAYLOAD: begin
        elem.marker = operand[7:0];
      end
      CMD_FLOAT32: begin
        elem.marker = MK_FLOAT32;
        elem.data = {operand[31:0], 32'd0};
        elem.nbytes = 4'd4;
      end
      CMD_BOOL: begin
        elem.marker = operand[0] ? MK_TRUE : MK_FALSE;
      end
      default: begin
        // An unknown command produces no bytes at all.
        elem_valid = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mve_queue.sv =====
`default_nettype none
module mve_queue #(
  parameter int DEPTH = mve_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire mve_pkg::elem_t wr_elem,
  input  wire logic           pop,
  output mve_pkg::elem_t      rd_elem,
  output mve_pkg::q_status_t  status
);
  import mve_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  elem_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign rd_elem = slots[rd_ptr];
  assign status.full = (fill == FULL_CNT);
  assign status.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_elem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/mve_back.sv =====
`default_nettype none
module mve_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mve_pkg::elem_t     head,
  input  wire mve_pkg::q_status_t q_status,
  output logic                    pop,
  output logic [7:0]              out_byte,
  output logic                    last,
  output logic                    strobe
);
  import mve_pkg::*;

  logic        active;
  logic        in_marker;
  logic [7:0]  marker;
  logic [63:0] data;
  logic [3:0]  nbytes;
  logic [3:0]  rem;
  logic        done_this;

  // The element in hand sends its final byte this cycle.
  assign done_this = active && ((in_marker && nbytes == 4'd0) ||
                                (!in_marker && rem == 4'd1));
  assign pop = !q_status.empty && (!active || done_this);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      in_marker <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (pop) begin
        active <= 1'b1;
        in_marker <= 1'b1;
      end else if (done_this) begin
        active <= 1'b0;
      end else if (active && in_marker) begin
        in_marker <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      last <= done_this;
      if (in_marker) begin
        out_byte <= marker;
        rem <= nbytes;
      end else begin
        out_byte <= data[63:56];
        rem <= rem - 1'b1;
      end
    end
    // A new element replaces the shift register when the old one finishes or the emitter is idle.
    if (pop) begin
      marker <= head.marker;
      data <= head.data;
      nbytes <= head.nbytes;
    end else if (active && !in_marker) begin
      data <= {data[55:0], 8'd0};
    end
  end

endmodule
`default_nettype wire
